// ===== rtl/circular_buffer_deque_unit_assert.svh =====
// Assertion macros for the circular buffer deque unit.
// The using module must provide clk and rst_n in scope.
`ifndef CIRCULAR_BUFFER_DEQUE_UNIT_ASSERT_SVH
`define CIRCULAR_BUFFER_DEQUE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbd_pkg.sv =====
// Shared types and constants of the circular buffer deque unit.
// No dependencies.
package cbd_pkg;

  localparam int WORD_W     = 32;
  localparam int CMD_W      = 3;
  localparam int ITEM_CNT_W = 7;
  localparam int STATUS_W   = 2;

  typedef logic [CMD_W-1:0]        cmd_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [ITEM_CNT_W-1:0]   item_cnt_t;
  typedef logic [STATUS_W-1:0]     status_t;

  localparam cmd_t CMD_PUSH_BACK  = 3'd0;
  localparam cmd_t CMD_PUSH_FRONT = 3'd1;
  localparam cmd_t CMD_POP_BACK   = 3'd2;
  localparam cmd_t CMD_POP_FRONT  = 3'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== rtl/cbd_in_if.sv =====
// Command channel of the deque unit: valid, ready, the command and the push value.
// Depends on cbd_pkg.
interface cbd_in_if import cbd_pkg::*;;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  word_t push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink (input valid, input cmd, input push_value, output ready);
endinterface

// ===== rtl/cbd_out_if.sv =====
// Result channel of the deque unit: valid, ready and the result word.
// Depends on cbd_pkg.
interface cbd_out_if import cbd_pkg::*;;
  logic      valid;
  logic      ready;
  word_t     popped_value;
  word_t     front_value;
  word_t     back_value;
  item_cnt_t item_count;
  logic      is_empty;
  status_t   status;

  modport source (output valid, output popped_value, output front_value,
                  output back_value, output item_count, output is_empty,
                  output status, input ready);
  modport sink (input valid, input popped_value, input front_value,
                input back_value, input item_count, input is_empty,
                input status, output ready);
endinterface

// ===== rtl/cbd_ram.sv =====
// Word store of the deque: one write port and one read port, registered read.
// Depends on cbd_pkg.
module cbd_ram import cbd_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  word_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output word_t         rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cbd_ctrl.sv =====
// Deque controller: pointers, count, cached end words and the result register.
// Depends on cbd_pkg and the two channel interfaces; drives the word store.
module cbd_ctrl import cbd_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  cbd_in_if.sink        in_ch,
  cbd_out_if.source     out_ch,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output word_t         mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  word_t         mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  word_t         front_r, front_nxt;
  word_t         back_r, back_nxt;
  word_t         popped_r, popped_nxt;
  status_t       status_r, status_nxt;
  logic          rd_front_r, rd_front_nxt;
  logic          load_out;
  logic          is_full, is_none, is_single;

  logic          out_valid_r;
  word_t         out_popped_r, out_front_r, out_back_r;
  item_cnt_t     out_count_r;
  logic          out_empty_r;
  status_t       out_status_r;

  function automatic logic [AW-1:0] idx_up(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dn(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign is_full   = (count_r == CW'(DEPTH));
  assign is_none   = (count_r == '0);
  assign is_single = (count_r == CW'(1));
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    popped_nxt   = popped_r;
    status_nxt   = status_r;
    rd_front_nxt = rd_front_r;
    mem_we       = 1'b0;
    mem_waddr    = tail_r;
    mem_wdata    = in_ch.push_value;
    mem_re       = 1'b0;
    mem_raddr    = head_r;
    load_out     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt  = S_FIN;
          status_nxt = ST_OK;
          popped_nxt = '0;
          unique case (in_ch.cmd)
            CMD_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_r;
                tail_nxt  = idx_up(tail_r);
                count_nxt = count_r + 1'b1;
                back_nxt  = in_ch.push_value;
                if (is_none) begin
                  front_nxt = in_ch.push_value;
                end
              end
            end
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = idx_dn(head_r);
                head_nxt  = idx_dn(head_r);
                count_nxt = count_r + 1'b1;
                front_nxt = in_ch.push_value;
                if (is_none) begin
                  back_nxt = in_ch.push_value;
                end
              end
            end
            CMD_POP_BACK: begin
              if (is_none) begin
                status_nxt = ST_EMPTY;
              end else begin
                popped_nxt = back_r;
                tail_nxt   = idx_dn(tail_r);
                count_nxt  = count_r - 1'b1;
                if (!is_single) begin
                  mem_re       = 1'b1;
                  mem_raddr    = idx_dn(idx_dn(tail_r));
                  rd_front_nxt = 1'b0;
                  state_nxt    = S_READ;
                end
              end
            end
            CMD_POP_FRONT: begin
              if (is_none) begin
                status_nxt = ST_EMPTY;
              end else begin
                popped_nxt = front_r;
                head_nxt   = idx_up(head_r);
                count_nxt  = count_r - 1'b1;
                if (!is_single) begin
                  mem_re       = 1'b1;
                  mem_raddr    = idx_up(head_r);
                  rd_front_nxt = 1'b1;
                  state_nxt    = S_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (rd_front_r) begin
          front_nxt = mem_rdata;
        end else begin
          back_nxt = mem_rdata;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    popped_r   <= popped_nxt;
    status_r   <= status_nxt;
    rd_front_r <= rd_front_nxt;
    if (load_out) begin
      out_popped_r <= popped_r;
      out_front_r  <= is_none ? '0 : front_r;
      out_back_r   <= is_none ? '0 : back_r;
      out_count_r  <= ITEM_CNT_W'(count_r);
      out_empty_r  <= is_none;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = out_popped_r;
  assign out_ch.front_value  = out_front_r;
  assign out_ch.back_value   = out_back_r;
  assign out_ch.item_count   = out_count_r;
  assign out_ch.is_empty     = out_empty_r;
  assign out_ch.status       = out_status_r;

endmodule

// ===== rtl/circular_buffer_deque_unit.sv =====
// Circular buffer deque unit: a fixed-capacity double-ended queue of 32-bit words.
// A push, a query or a pop that empties the store or finds it empty goes from acceptance
// via S_FIN to the result register; a pop that leaves words stored first passes S_READ.
// One command is in flight at a time, and the registered read that refills the cached end
// word is what needs S_READ; a held result stalls input.
// Reset clears the pointers, the count and the result valid; store contents stay undefined.
`include "circular_buffer_deque_unit_assert.svh"
module circular_buffer_deque_unit import cbd_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  cbd_in_if.sink    in_ch,
  cbd_out_if.source out_ch
);

  localparam int AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;
  logic          ends_zero;
  logic          is_underflow;
  logic          underflow_ok;
  logic          status_known;

  cbd_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cbd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  assign ends_zero    = (out_ch.front_value == '0) && (out_ch.back_value == '0);
  assign is_underflow = (out_ch.status == ST_EMPTY);
  assign underflow_ok = out_ch.is_empty && (out_ch.popped_value == '0);
  assign status_known = (out_ch.status == ST_OK) || (out_ch.status == ST_FULL) ||
                        (out_ch.status == ST_EMPTY);

  `CBD_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "accept while busy")
  `CBD_ASSERT_SAME(a_empty_zero, out_ch.valid && out_ch.is_empty, ends_zero, "stale end words")
  `CBD_ASSERT_SAME(a_underflow_empty, out_ch.valid && is_underflow, underflow_ok, "bad underflow")
  `CBD_ASSERT_SAME(a_status_code, out_ch.valid, status_known, "undefined status code")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of circular_buffer_deque_unit: a directed table, a fill and
// drain past capacity, random command mixes, scored by fixed rows or a deque predictor.
// Depends on cbd_pkg, cbd_in_if, cbd_out_if and the unit itself.
module testbench;
  import cbd_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD_AT = 200;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_PAUSE_AT = 420;
  localparam int SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 300000;

  localparam cmd_t CMD_QUERY   = 3'd4;
  localparam cmd_t CMD_SPARE_A = 3'd5;
  localparam cmd_t CMD_SPARE_B = 3'd6;
  localparam cmd_t CMD_SPARE_C = 3'd7;

  localparam word_t WORD_MAX = 32'h7FFF_FFFF;
  localparam word_t WORD_MIN = 32'h8000_0000;

  typedef struct packed {
    word_t     popped;
    word_t     front;
    word_t     back;
    item_cnt_t count;
    logic      empty;
    status_t   status;
  } deque_result_t;

  typedef struct packed {
    cmd_t          cmd;
    word_t         value;
    logic          fixed;
    deque_result_t want;
  } deque_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  localparam deque_result_t IDLE_RESULT = '{popped: '0, front: '0, back: '0, count: '0,
                                             empty: 1'b1, status: ST_OK};
  localparam deque_result_t EMPTY_POP = '{popped: '0, front: '0, back: '0, count: '0,
                                           empty: 1'b1, status: ST_EMPTY};
  localparam deque_result_t ONE_MAX = '{popped: '0, front: WORD_MAX, back: WORD_MAX,
                                         count: 7'd1, empty: 1'b0, status: ST_OK};
  localparam deque_result_t MIN_MAX = '{popped: '0, front: WORD_MIN, back: WORD_MAX,
                                         count: 7'd2, empty: 1'b0, status: ST_OK};

  deque_row_t dir_rows [21] = '{
    '{CMD_QUERY,      32'h0000_0000, 1'b1, IDLE_RESULT},
    '{CMD_POP_BACK,   32'h0000_1234, 1'b1, EMPTY_POP},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, EMPTY_POP},
    '{CMD_SPARE_A,    32'hFFFF_FFFF, 1'b1, IDLE_RESULT},
    '{CMD_SPARE_B,    32'h5555_5555, 1'b1, IDLE_RESULT},
    '{CMD_SPARE_C,    32'hAAAA_AAAA, 1'b1, IDLE_RESULT},
    '{CMD_PUSH_BACK,  WORD_MAX,      1'b1, ONE_MAX},
    '{CMD_PUSH_FRONT, WORD_MIN,      1'b1, MIN_MAX},
    '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, '0},
    '{CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, '0},
    '{CMD_QUERY,      32'h0000_5A5A, 1'b0, '0},
    '{CMD_SPARE_C,    32'h0000_0000, 1'b0, '0},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{CMD_PUSH_BACK,  32'h5555_5555, 1'b0, '0},
    '{CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, EMPTY_POP}
  };

  logic clk;
  logic rst_n;

  cbd_in_if  in_ch ();
  cbd_out_if out_ch ();

  circular_buffer_deque_unit #(.DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_t         ring_words [DEPTH];
  logic [5:0]    head_pos = '0;
  logic [5:0]    tail_pos = '0;
  int unsigned   fill = 0;
  deque_result_t pending_results [$];
  int            sent_items = 0;
  int            mismatches = 0;
  logic          long_hold_done = 1'b0;

  function automatic deque_result_t deque_next(cmd_t c, word_t v);
    deque_result_t r;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (c == CMD_PUSH_BACK) begin
          ring_words[tail_pos] = v;
          tail_pos++;
          fill++;
        end else begin
          head_pos--;
          ring_words[head_pos] = v;
          fill++;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (c == CMD_POP_BACK) begin
          tail_pos--;
          r.popped = ring_words[tail_pos];
          fill--;
        end else begin
          r.popped = ring_words[head_pos];
          head_pos++;
          fill--;
        end
      end
      default: ;
    endcase
    if (fill != 0) begin
      r.front = ring_words[head_pos];
      r.back = ring_words[tail_pos - 6'd1];
    end
    r.count = fill[6:0];
    r.empty = (fill == 0);
    return r;
  endfunction

  function automatic word_t random_word();
    case ($urandom_range(0, 19))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return -32'sd1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic cmd_t pick_cmd(mix_t mix);
    int push_pct;
    if ($urandom_range(0, 99) < 4) return cmd_t'($urandom_range(4, 7));
    push_pct = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 15 : 50;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  task automatic offer(cmd_t c, word_t v, logic fixed, deque_result_t want);
    deque_result_t model;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.push_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    model = deque_next(c, v);
    pending_results.insert(pending_results.size(), fixed ? want : model);
    sent_items++;
  endtask

  task automatic sender_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (sent_items == DRAIN_PAUSE_AT) begin
      // Hold the next word back until the unit has answered everything sent so far.
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
      return;
    end
    gap = (r < 55) ? 0 : (r < 85) ? $urandom_range(1, 3) :
          (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic compare_field(string field, logic signed [63:0] want,
                               logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_sink
    int r;
    int run;
    int hold;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && sent_items >= LONG_HOLD_AT) begin
        // A long stall backs the unit up so that its command input stalls too.
        out_ch.ready <= 1'b0;
        long_hold_done = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      r = $urandom_range(0, 99);
      hold = (r < 70) ? 0 : (r < 90) ? $urandom_range(1, 3) :
             (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    deque_result_t got;
    deque_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.popped_value, out_ch.front_value, out_ch.back_value,
              out_ch.item_count, out_ch.is_empty, out_ch.status};
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("popped_value", want.popped, got.popped);
        compare_field("front_value", want.front, got.front);
        compare_field("back_value", want.back, got.back);
        compare_field("item_count", want.count, got.count);
        compare_field("is_empty", want.empty, got.empty);
        compare_field("status", want.status, got.status);
      end
    end
  end

  initial begin : stimulus
    mix_t mix;
    int   left;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_QUERY;
    in_ch.push_value = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].want);
      sender_gap();
    end

    // Fill past capacity from both ends, then drain past empty.
    repeat (DEPTH + 2) begin
      offer($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_word(), 1'b0, '0);
      sender_gap();
    end
    repeat (DEPTH + 2) begin
      offer($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, random_word(), 1'b0, '0);
      sender_gap();
    end

    left = 0;
    mix = MIX_EVEN;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (left == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        left = $urandom_range(30, 120);
      end
      left--;
      offer(pick_cmd(mix), random_word(), 1'b0, '0);
      sender_gap();
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbd_pkg.sv
rtl/cbd_in_if.sv
rtl/cbd_out_if.sv
rtl/cbd_ram.sv
rtl/cbd_ctrl.sv
rtl/circular_buffer_deque_unit.sv
tb/sv/testbench.sv
